>>> design/lsc_pkg.sv
package lsc_pkg;

    localparam int NODES_DEFAULT = 5;
    localparam int TABLE_NODES   = 5;
    localparam int OUT_FRAC_BITS = 30;

    localparam int Y_FRAC = 30;
    localparam int Q_W    = 27;
    localparam int W_W    = Q_W + 1;
    localparam int PW     = 34;
    localparam int CW     = 32;

    localparam logic [31:0] TWO_OVER_PI = 32'hA2F9836E;
    localparam longint      P_LIMIT     = 64'sd1 << 32;
    localparam longint      Y_ONE       = 64'sd1 << Y_FRAC;

    typedef struct packed {
        logic           vld;
        logic           neg;
        logic [W_W-1:0] w;
    } tag_t;

    function automatic int node_count(input int n);
        int c;
        c = n;
        if (c > TABLE_NODES) c = TABLE_NODES;
        if (c < 1) c = 1;
        return c;
    endfunction

    // node positions in sixths of a quarter turn
    function automatic int node_sixths(input int idx);
        int r;
        case (idx)
            0:       r = 0;
            1:       r = 2;
            2:       r = 3;
            3:       r = 4;
            default: r = 6;
        endcase
        return r;
    endfunction

    // sine at the nodes, Q30
    function automatic int node_y(input int idx);
        int r;
        case (idx)
            0:       r = 0;
            1:       r = 536870912;
            2:       r = 759250125;
            3:       r = 929887697;
            default: r = 1073741824;
        endcase
        return r;
    endfunction

endpackage

>>> design/lsc_nev_level.sv
// One Neville level: p_i = trunc(p_(i+1) + c * (p_(i+1) - p_i) / 2^sh), saturated
module lsc_nev_level #(
    parameter int K   = 1,
    parameter int CNT = 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lsc_pkg::tag_t                     in_tag,
    output logic                              in_ready,
    input  logic [CNT:0][lsc_pkg::PW-1:0]     p_in,
    output lsc_pkg::tag_t                     out_tag,
    input  logic                              out_ready,
    output logic [CNT-1:0][lsc_pkg::PW-1:0]   p_out
);

    localparam int PW = lsc_pkg::PW;
    localparam int CW = lsc_pkg::CW;

    lsc_pkg::tag_t tag_a_reg;
    lsc_pkg::tag_t tag_b_reg;
    logic          rdy_a;
    logic          rdy_b;

    assign rdy_b    = !tag_b_reg.vld || out_ready;
    assign rdy_a    = !tag_a_reg.vld || rdy_b;
    assign in_ready = rdy_a;
    assign out_tag  = tag_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg.vld <= 1'b0;
            tag_b_reg.vld <= 1'b0;
        end else begin
            if (rdy_a) tag_a_reg <= in_tag;
            if (rdy_b) tag_b_reg <= tag_a_reg;
        end
    end

    for (genvar i = 0; i < CNT; i++) begin : g_pt
        localparam int SJ    = lsc_pkg::node_sixths(i + K);
        localparam int SI    = lsc_pkg::node_sixths(i);
        localparam int D     = SJ - SI;
        // where d holds a factor three, so does the node distance
        localparam bit THIRD = (D % 3) == 0;
        localparam int CM    = THIRD ? 2 : 6;
        localparam int CO    = THIRD ? SJ / 3 : SJ;
        localparam int DP    = THIRD ? D / 3 : D;
        localparam int SH    = lsc_pkg::Q_W + $clog2(DP);

        logic signed [CW-1:0] c;
        logic signed [PW:0]   dlt;
        logic signed [63:0]   prod_next;
        logic signed [63:0]   prod_reg;
        logic signed [PW-1:0] phi_reg;
        logic signed [39:0]   fl;
        logic signed [39:0]   sm;
        logic signed [39:0]   rs;
        logic                 rem;
        logic signed [PW-1:0] pv_next;
        logic signed [PW-1:0] pv_reg;

        assign c = $signed(CW'(CM) * CW'(in_tag.w)) - $signed(CW'(CO) << lsc_pkg::Q_W);
        assign dlt = $signed({p_in[i+1][PW-1], p_in[i+1]}) - $signed({p_in[i][PW-1], p_in[i]});
        assign prod_next = 64'(c) * 64'(dlt);

        always_ff @(posedge aclk) begin
            if (rdy_a) begin
                prod_reg <= prod_next;
                phi_reg  <= $signed(p_in[i+1]);
            end
        end

        assign fl  = 40'(prod_reg >>> SH);
        assign rem = |prod_reg[SH-1:0];
        assign sm  = 40'(phi_reg) + fl;

        always_comb begin
            rs = (sm < 0 && rem) ? sm + 40'sd1 : sm;
            if (rs > 40'(lsc_pkg::P_LIMIT)) begin
                rs = 40'(lsc_pkg::P_LIMIT);
            end else if (rs < -40'(lsc_pkg::P_LIMIT)) begin
                rs = -40'(lsc_pkg::P_LIMIT);
            end
            pv_next = PW'(rs);
        end

        always_ff @(posedge aclk) begin
            if (rdy_b) pv_reg <= pv_next;
        end

        assign p_out[i] = pv_reg;
    end

endmodule

>>> design/lagrange_sine_cosine_unit.sv
// Channel  Dir  tvalid/tready       tdata / tuser
// s_       in   s_tvalid, s_tready  tdata: angle[31:0] Q8.24 rad; tuser: func (0 sin, 1 cos)
// m_       out  m_tvalid, m_tready  tdata: value[31:0] signed, OUT_FRAC_BITS fraction bits
//
// One word per clock sustained while m_tready is high.
// Each Neville level takes two stages: multiply, then shift, add and saturate.
// Reset (aresetn low, synchronous) empties every stage.
// Per-stage ready chain: a bubble anywhere lets a word in while the output stalls.
module lagrange_sine_cosine_unit #(
    parameter int NODES = lsc_pkg::NODES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);

    localparam int NN = lsc_pkg::node_count(NODES);
    localparam int PW = lsc_pkg::PW;
    localparam int QW = lsc_pkg::Q_W;
    localparam int SR = lsc_pkg::Y_FRAC - lsc_pkg::OUT_FRAC_BITS;

    // stage 1: magnitude
    logic        vld1_reg, func1_reg, aneg1_reg;
    logic [31:0] amag1_reg;
    // stage 2: quarter turns, Q56
    logic        vld2_reg, func2_reg, aneg2_reg;
    logic [63:0] pq2_reg;
    // stage 3: quadrant and fraction
    logic        vld3_reg, neg3_reg;
    logic [1:0]  q3_reg;
    logic [QW-1:0] f3_reg;
    // stage 4: folded angle
    lsc_pkg::tag_t tag4_reg;
    // final stages
    logic               vld5_reg;
    logic signed [31:0] v5_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

    lsc_pkg::tag_t                tag_lvl [NN];
    logic                         lvl_rdy [NN];
    logic [NN-1:0][PW-1:0]        p_lvl   [NN];

    assign rdy_out  = !m_tvalid_reg || m_tready;
    assign rdy5     = !vld5_reg || rdy_out;
    assign lvl_rdy[NN-1] = rdy5;
    assign rdy4     = !tag4_reg.vld || lvl_rdy[0];
    assign rdy3     = !vld3_reg || rdy4;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign s_tready = rdy1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // stage 1
    logic [31:0] amag_next;
    assign amag_next = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;

    // stage 3: cosine is sin of one quarter turn minus the angle
    logic [57:0] m_next;
    logic        neg3_next;
    always_comb begin
        neg3_next = 1'b0;
        if (!func2_reg) begin
            neg3_next = aneg2_reg;
            m_next    = pq2_reg[57:0];
        end else if (aneg2_reg) begin
            m_next    = pq2_reg[57:0] + (58'd1 << 56);
        end else if (pq2_reg <= (64'd1 << 56)) begin
            m_next    = (58'd1 << 56) - pq2_reg[57:0];
        end else begin
            neg3_next = 1'b1;
            m_next    = pq2_reg[57:0] - (58'd1 << 56);
        end
    end

    // stage 4: fold into first quadrant
    lsc_pkg::tag_t tag4_next;
    always_comb begin
        tag4_next.vld = vld3_reg;
        tag4_next.neg = neg3_reg ^ q3_reg[1];
        tag4_next.w   = q3_reg[0] ? ((lsc_pkg::W_W)'(1) << QW) - {1'b0, f3_reg}
                                  : {1'b0, f3_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            vld3_reg     <= 1'b0;
            tag4_reg.vld <= 1'b0;
            vld5_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= s_tvalid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) tag4_reg <= tag4_next;
            if (rdy5) vld5_reg <= tag_lvl[NN-1].vld;
            if (rdy_out) m_tvalid_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            func1_reg <= s_tuser;
            aneg1_reg <= s_tdata[31];
            amag1_reg <= amag_next;
        end
        if (rdy2) begin
            func2_reg <= func1_reg;
            aneg2_reg <= aneg1_reg;
            pq2_reg   <= 64'(amag1_reg) * 64'(lsc_pkg::TWO_OVER_PI);
        end
        if (rdy3) begin
            neg3_reg <= neg3_next;
            q3_reg   <= m_next[57:56];
            f3_reg   <= m_next[55:56-QW];
        end
    end

    // Neville levels
    assign tag_lvl[0] = tag4_reg;
    for (genvar i = 0; i < NN; i++) begin : g_y
        assign p_lvl[0][i] = PW'(lsc_pkg::node_y(i));
    end

    for (genvar k = 1; k < NN; k++) begin : g_lvl
        lsc_nev_level #(
            .K   (k),
            .CNT (NN - k)
        ) u_lvl (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_tag    (tag_lvl[k-1]),
            .in_ready  (lvl_rdy[k-1]),
            .p_in      (p_lvl[k-1][NN-k:0]),
            .out_tag   (tag_lvl[k]),
            .out_ready (lvl_rdy[k]),
            .p_out     (p_lvl[k][NN-k-1:0])
        );
        assign p_lvl[k][NN-1:NN-k] = '0;
    end

    // stage 5: sign and clamp to +-1
    logic signed [PW:0] p0;
    logic signed [PW:0] vn;
    logic signed [31:0] v5_next;
    always_comb begin
        p0 = (PW+1)'($signed(p_lvl[NN-1][0]));
        vn = tag_lvl[NN-1].neg ? -p0 : p0;
        if (vn > (PW+1)'(lsc_pkg::Y_ONE)) begin
            vn = (PW+1)'(lsc_pkg::Y_ONE);
        end else if (vn < -(PW+1)'(lsc_pkg::Y_ONE)) begin
            vn = -(PW+1)'(lsc_pkg::Y_ONE);
        end
        v5_next = 32'(vn);
    end

    // stage 6: round half away from zero to output precision
    logic [30:0] mag;
    logic [30:0] magr;
    logic [31:0] mag32;
    assign mag = v5_reg[31] ? 31'(-v5_reg) : 31'(v5_reg);

    if (SR > 0) begin : g_rnd
        assign magr = 31'((32'(mag) + (32'd1 << (SR - 1))) >> SR);
    end else begin : g_nornd
        assign magr = mag;
    end

    assign mag32 = {1'b0, magr};

    always_ff @(posedge aclk) begin
        if (rdy5) v5_reg <= v5_next;
        if (rdy_out) m_tdata_reg <= v5_reg[31] ? -mag32 : mag32;
    end

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= 32'sd1073741824 &&
                      $signed(m_tdata) >= -32'sd1073741824))
        else $error("result beyond plus or minus one");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output stage");

    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tag4_reg.vld |-> tag4_reg.w <= ((lsc_pkg::W_W)'(1) << QW))
        else $error("folded angle beyond one quarter turn");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld5_reg && !rdy5 |=> vld5_reg && $stable(v5_reg))
        else $error("stalled final stage lost its word");

endmodule
